/* hw/rtl/wcf_pkg.sv */
// ----------------------------------------------------------------------------
// Wolff cluster flip package
// Shared types, register indexes and field widths for the cluster flip block.
// ----------------------------------------------------------------------------
package wcf_pkg;

    localparam int SITE_W     = 12;
    localparam int SIZE_W     = 13;
    localparam int SIDE_W     = 7;
    localparam int THR_W      = 16;
    localparam int SEED_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd2;

    localparam logic MODE_FLIP = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [SEED_W-1:0] LFSR_TAPS = 32'h8020_0003;

    // Lattice geometry after clamping.
    typedef struct packed {
        logic [SIDE_W-1:0] side;
        logic [SIZE_W-1:0] count;
    } lat_cfg_t;

    typedef struct packed {
        logic [SIZE_W-1:0] cluster_size;
        logic              spin_value;
        logic              bad_site;
    } res_t;

endpackage

/* hw/rtl/wcf_ram.sv */
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port, read data registered, write-first on a
// read of the address written in the same cycle.
// ----------------------------------------------------------------------------
module wcf_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/wcf_bond_rng.sv */
// ----------------------------------------------------------------------------
// Bond acceptance generator
// 32-bit Galois LFSR; each step compares the top bits of the new state with
// the scaled acceptance threshold.
// ----------------------------------------------------------------------------
module wcf_bond_rng #(
    parameter int PROB_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic [wcf_pkg::SEED_W-1:0] seed,
    input  logic                       step,
    input  logic [wcf_pkg::THR_W-1:0]  threshold,
    output logic                       accept
);

    import wcf_pkg::*;

    logic [SEED_W-1:0]    lfsr_reg;
    logic [SEED_W-1:0]    lfsr_next;
    logic [PROB_BITS-1:0] draw;
    logic [PROB_BITS-1:0] thr_scaled;

    always_comb begin
        lfsr_next = lfsr_reg >> 1;
        if (lfsr_reg[0]) begin
            lfsr_next = lfsr_next ^ LFSR_TAPS;
        end
    end

    assign draw = lfsr_next[SEED_W-1 -: PROB_BITS];

    generate
        if (PROB_BITS >= THR_W) begin : g_widen
            assign thr_scaled = PROB_BITS'(threshold) << (PROB_BITS - THR_W);
        end else begin : g_narrow
            assign thr_scaled = threshold[THR_W-1 -: PROB_BITS];
        end
    endgenerate

    assign accept = (draw < thr_scaled);

    // A zero seed would lock the register up, so it loads as one.
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            lfsr_reg <= SEED_W'(1);
        end else if (load) begin
            lfsr_reg <= (seed == '0) ? SEED_W'(1) : seed;
        end else if (step) begin
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

/* hw/rtl/wcf_seq.sv */
// ----------------------------------------------------------------------------
// Cluster growth sequencer
// Sets the spin memory to all ones after reset, then serves reads, and serves cluster
// flips by popping sites from the stack memory and testing their four neighbors.
// ----------------------------------------------------------------------------
module wcf_seq #(
    parameter int MAX_SITES = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  wcf_pkg::lat_cfg_t              cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_mode,
    input  logic [wcf_pkg::SITE_W-1:0]     in_site,
    output logic                           out_valid,
    input  logic                           out_ready,
    output wcf_pkg::res_t                  out_res,
    output logic                           rng_step,
    input  logic                           rng_accept,
    output logic                           spin_we,
    output logic [$clog2(MAX_SITES)-1:0]   spin_waddr,
    output logic                           spin_wdata,
    output logic [$clog2(MAX_SITES)-1:0]   spin_raddr,
    input  logic                           spin_rdata,
    output logic                           stk_we,
    output logic [$clog2(MAX_SITES)-1:0]   stk_waddr,
    output logic [$clog2(MAX_SITES)-1:0]   stk_wdata,
    output logic [$clog2(MAX_SITES)-1:0]   stk_raddr,
    input  logic [$clog2(MAX_SITES)-1:0]   stk_rdata
);

    import wcf_pkg::*;

    localparam int AW = $clog2(MAX_SITES);
    localparam int NW = AW + 1;

    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_SITES - 1);
    localparam logic [AW:0]   SP_MAX   = (AW + 1)'(MAX_SITES);

    localparam logic [1:0] NB_PLUS1  = 2'd0;
    localparam logic [1:0] NB_MINUS1 = 2'd1;
    localparam logic [1:0] NB_PLUSL  = 2'd2;
    localparam logic [1:0] NB_MINUSL = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEED,
        S_POP,
        S_CUR,
        S_NB
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     clr_reg;
    logic              mode_reg;
    logic              bad_reg;
    logic [AW-1:0]     site_reg;
    logic              old_reg;
    logic [AW:0]       sp_reg;
    logic [SIZE_W-1:0] count_reg;
    logic [AW-1:0]     cur_reg;
    logic [AW-1:0]     nb_reg;
    logic [1:0]        k_reg;
    logic              out_valid_reg;
    res_t              out_res_reg;

    logic [NW-1:0]     lat_side;
    logic [NW-1:0]     lat_count;
    logic [AW-1:0]     nb_first;
    logic [AW-1:0]     nb_follow;
    logic              join_nb;
    logic              push;
    logic              out_free;

    // Helical neighbor: offsets +1, -1, +L, -L taken modulo the site count.
    function automatic logic [AW-1:0] nb_addr(input logic [AW-1:0] cur,
                                              input logic [1:0]    k,
                                              input logic [NW-1:0] l,
                                              input logic [NW-1:0] n);
        logic [NW-1:0] c;
        logic [NW-1:0] t;
        c = NW'(cur);
        case (k)
            NB_PLUS1: begin
                t = c + NW'(1);
                if (t >= n) begin
                    t = t - n;
                end
            end
            NB_MINUS1: begin
                t = (c == '0) ? (n - NW'(1)) : (c - NW'(1));
            end
            NB_PLUSL: begin
                t = c + l;
                if (t >= n) begin
                    t = t - n;
                end
            end
            default: begin
                t = (c < l) ? (c + n - l) : (c - l);
            end
        endcase
        return AW'(t);
    endfunction

    assign lat_side  = NW'(cfg.side);
    assign lat_count = NW'(cfg.count);
    assign nb_first  = nb_addr(stk_rdata, NB_PLUS1, lat_side, lat_count);
    assign nb_follow = nb_addr(cur_reg, 2'(k_reg + 2'd1), lat_side, lat_count);
    assign join_nb   = (spin_rdata == old_reg);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb begin
        spin_we    = 1'b0;
        spin_waddr = nb_reg;
        spin_wdata = !old_reg;
        spin_raddr = site_reg;
        stk_we     = 1'b0;
        stk_waddr  = sp_reg[AW-1:0];
        stk_wdata  = nb_reg;
        stk_raddr  = AW'(sp_reg - (AW + 1)'(1));
        rng_step   = 1'b0;
        push       = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                spin_we    = 1'b1;
                spin_waddr = clr_reg;
                spin_wdata = 1'b1;
            end
            S_IDLE: begin
                spin_raddr = AW'(in_site);
            end
            S_SEED: begin
                if (!bad_reg && (mode_reg == MODE_FLIP)) begin
                    spin_we    = 1'b1;
                    spin_waddr = site_reg;
                    spin_wdata = !spin_rdata;
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = site_reg;
                end
            end
            S_CUR: begin
                spin_raddr = nb_first;
            end
            S_NB: begin
                // A neighbor that still has the old sign draws one number.
                rng_step   = join_nb;
                spin_we    = join_nb && rng_accept;
                push       = join_nb && rng_accept && (sp_reg < SP_MAX);
                stk_we     = push;
                spin_raddr = nb_follow;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == CLR_LAST) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_valid) begin
                        mode_reg  <= in_mode;
                        site_reg  <= AW'(in_site);
                        bad_reg   <= ({1'b0, in_site} >= cfg.count);
                        state_reg <= S_SEED;
                    end
                end
                S_SEED: begin
                    if (bad_reg || (mode_reg == MODE_READ)) begin
                        if (out_free) begin
                            out_valid_reg            <= 1'b1;
                            out_res_reg.cluster_size <= '0;
                            out_res_reg.spin_value   <= !bad_reg && spin_rdata;
                            out_res_reg.bad_site     <= bad_reg;
                            state_reg                <= S_IDLE;
                        end
                    end else begin
                        old_reg   <= spin_rdata;
                        sp_reg    <= (AW + 1)'(1);
                        count_reg <= SIZE_W'(1);
                        state_reg <= S_POP;
                    end
                end
                S_POP: begin
                    if (sp_reg == '0) begin
                        if (out_free) begin
                            out_valid_reg            <= 1'b1;
                            out_res_reg.cluster_size <= count_reg;
                            out_res_reg.spin_value   <= old_reg;
                            out_res_reg.bad_site     <= 1'b0;
                            state_reg                <= S_IDLE;
                        end
                    end else begin
                        sp_reg    <= sp_reg - (AW + 1)'(1);
                        state_reg <= S_CUR;
                    end
                end
                S_CUR: begin
                    cur_reg   <= stk_rdata;
                    nb_reg    <= nb_first;
                    k_reg     <= NB_PLUS1;
                    state_reg <= S_NB;
                end
                S_NB: begin
                    if (push) begin
                        sp_reg    <= sp_reg + (AW + 1)'(1);
                        count_reg <= count_reg + SIZE_W'(1);
                    end
                    if (k_reg == NB_MINUSL) begin
                        state_reg <= S_POP;
                    end else begin
                        k_reg  <= 2'(k_reg + 2'd1);
                        nb_reg <= nb_follow;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    a_accept_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (sp_reg == '0))
        else $error("item accepted while the site stack is not empty");

    a_bad_site_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.bad_site) |->
            ((out_res_reg.cluster_size == '0) && !out_res_reg.spin_value))
        else $error("bad site result carries a size or a spin");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NB) |-> (count_reg <= cfg.count))
        else $error("cluster size exceeds the site count");

    a_result_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (sp_reg == '0))
        else $error("result issued before the stack drained");

endmodule

/* hw/rtl/wolff_cluster_flip.sv */
// A read or a bad site gives its result from the seed state once the output register is free;
// a cluster flip gives it once the site stack has drained and the output register is free.
// Each popped site passes through a stack read, a neighbor setup and one read-test-write
// per neighbor on the spin memory. A new item is taken in the cycle after the result
// is registered, so no new item is taken before the last one is done.
// After reset the spin memory is set to all ones, site by site, with s_tready low.
// ----------------------------------------------------------------------------
// Wolff cluster flip
// Keeps a lattice of one-bit spins in memory and grows and flips Wolff
// clusters with helical wrap, or reads a single spin.
// ----------------------------------------------------------------------------
module wolff_cluster_flip #(
    parameter int MAX_SITES = 4096,
    parameter int PROB_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // [11:0] site
    input  logic [0:0]                     s_tuser,   // [0] mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [12:0] cluster_size, [13] spin_value
    output logic [0:0]                     m_tuser,   // [0] bad_site
    input  logic                           cfg_we,
    input  logic [wcf_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [wcf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import wcf_pkg::*;

    localparam int AW = $clog2(MAX_SITES);

    function automatic int max_side(input int sites);
        int r;
        r = 2;
        for (int i = 2; i <= 64; i++) begin
            if (i * i <= sites) begin
                r = i;
            end
        end
        return r;
    endfunction

    localparam int               SIDE_MAX_I = max_side(MAX_SITES);
    localparam logic [SIDE_W-1:0] SIDE_MAX  = SIDE_W'(SIDE_MAX_I);
    localparam logic [SIZE_W-1:0] COUNT_RST = SIZE_W'(SIDE_MAX_I * SIDE_MAX_I);

    logic [SIDE_W-1:0] side_reg;
    logic [SIZE_W-1:0] count_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [SIDE_W-1:0] side_next;
    logic [SIZE_W-1:0] count_next;

    lat_cfg_t lat_cfg;
    res_t     res;

    logic          rng_step;
    logic          rng_accept;
    logic          spin_we;
    logic [AW-1:0] spin_waddr;
    logic          spin_wdata;
    logic [AW-1:0] spin_raddr;
    logic          spin_rdata;
    logic          stk_we;
    logic [AW-1:0] stk_waddr;
    logic [AW-1:0] stk_wdata;
    logic [AW-1:0] stk_raddr;
    logic [AW-1:0] stk_rdata;

    // The side is clamped when written, so the lattice always fits the store.
    always_comb begin
        side_next = cfg_wdata[SIDE_W-1:0];
        if (side_next < SIDE_W'(2)) begin
            side_next = SIDE_W'(2);
        end else if (side_next > SIDE_MAX) begin
            side_next = SIDE_MAX;
        end
        count_next = SIZE_W'(14'(side_next) * 14'(side_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg  <= SIDE_MAX;
            count_reg <= COUNT_RST;
            thr_reg   <= 16'h8000;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SIDE: begin
                    side_reg  <= side_next;
                    count_reg <= count_next;
                end
                REG_THRESH: begin
                    thr_reg <= cfg_wdata[THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign lat_cfg.side  = side_reg;
    assign lat_cfg.count = count_reg;

    wcf_bond_rng #(
        .PROB_BITS (PROB_BITS)
    ) u_rng (
        .clk       (aclk),
        .rst_n     (aresetn),
        .load      (cfg_we && (cfg_addr == REG_SEED)),
        .seed      (cfg_wdata[SEED_W-1:0]),
        .step      (rng_step),
        .threshold (thr_reg),
        .accept    (rng_accept)
    );

    wcf_ram #(
        .DEPTH (MAX_SITES),
        .WIDTH (1)
    ) u_spin_mem (
        .clk   (aclk),
        .we    (spin_we),
        .waddr (spin_waddr),
        .wdata (spin_wdata),
        .raddr (spin_raddr),
        .rdata (spin_rdata)
    );

    wcf_ram #(
        .DEPTH (MAX_SITES),
        .WIDTH (AW)
    ) u_stack_mem (
        .clk   (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    wcf_seq #(
        .MAX_SITES (MAX_SITES)
    ) u_seq (
        .clk        (aclk),
        .rst_n      (aresetn),
        .cfg        (lat_cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser[0]),
        .in_site    (s_tdata[SITE_W-1:0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res),
        .rng_step   (rng_step),
        .rng_accept (rng_accept),
        .spin_we    (spin_we),
        .spin_waddr (spin_waddr),
        .spin_wdata (spin_wdata),
        .spin_raddr (spin_raddr),
        .spin_rdata (spin_rdata),
        .stk_we     (stk_we),
        .stk_waddr  (stk_waddr),
        .stk_wdata  (stk_wdata),
        .stk_raddr  (stk_raddr),
        .stk_rdata  (stk_rdata)
    );

    assign m_tdata = {2'b00, res.spin_value, res.cluster_size};
    assign m_tuser = res.bad_site;

endmodule
